[design/particle_sensor_frame_parser_macros.svh]
// Assertion macros for the particle sensor frame parser checker.
// Expect clk and rst_n in the scope of use; no other dependencies.
`ifndef PARTICLE_SENSOR_FRAME_PARSER_MACROS_SVH
`define PARTICLE_SENSOR_FRAME_PARSER_MACROS_SVH

// same-cycle implication
`define PSFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/psfp_pkg.sv]
// Shared types and constants for the particle sensor frame parser.
// No dependencies.
package psfp_pkg;

  localparam logic [1:0] KIND_SHORT = 2'd0;
  localparam logic [1:0] KIND_LONG  = 2'd1;
  localparam logic [1:0] KIND_NACK  = 2'd2;
  localparam logic [1:0] KIND_ACK   = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_HEADER   = 2'd1;
  localparam logic [1:0] STAT_CHECKSUM = 2'd2;
  localparam logic [1:0] STAT_BODY     = 2'd3;

  localparam logic [7:0] ID_SHORT = 8'h40;
  localparam logic [7:0] ID_LONG  = 8'h42;
  localparam logic [7:0] ID_NACK  = 8'h96;
  localparam logic [7:0] ID_ACK   = 8'hA5;

  localparam logic [7:0] SHORT_HDR1 = 8'h05;
  localparam logic [7:0] SHORT_HDR2 = 8'h04;
  localparam logic [7:0] LONG_HDR1  = 8'h4D;
  localparam logic [7:0] LONG_HDR2  = 8'h00;
  localparam logic [7:0] LONG_HDR3  = 8'd28;

  localparam int unsigned POS_W = 5;

  localparam logic [POS_W-1:0] SHORT_LAST    = 5'd7;
  localparam logic [POS_W-1:0] LONG_LAST     = 5'd31;
  localparam logic [POS_W-1:0] LONG_CSUM_HI  = 5'd30;
  localparam logic [POS_W-1:0] REPLY_LAST    = 5'd1;

  localparam logic REG_SENSOR_ON     = 1'b0;
  localparam logic REG_SETTLE_FRAMES = 1'b1;

  typedef struct packed {
    logic [1:0]       kind;
    logic [POS_W-1:0] pos;
    logic [7:0]       data;
    logic             last;
  } item_t;

endpackage

[design/psfp_front.sv]
// Front end: finds frame ids, tracks frame position and tags each word.
// Depends on psfp_pkg.
module psfp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  output logic                push,
  output psfp_pkg::item_t     item
);

  logic                       active_r, active_nxt;
  logic [1:0]                 kind_r, kind_nxt;
  logic [psfp_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic                       is_id;
  logic [1:0]                 id_kind;
  logic                       last;

  always_comb begin
    is_id   = 1'b1;
    id_kind = psfp_pkg::KIND_SHORT;
    case (in_byte)
      psfp_pkg::ID_SHORT: id_kind = psfp_pkg::KIND_SHORT;
      psfp_pkg::ID_LONG:  id_kind = psfp_pkg::KIND_LONG;
      psfp_pkg::ID_NACK:  id_kind = psfp_pkg::KIND_NACK;
      psfp_pkg::ID_ACK:   id_kind = psfp_pkg::KIND_ACK;
      default:            is_id = 1'b0;
    endcase
  end

  always_comb begin
    case (kind_r)
      psfp_pkg::KIND_SHORT: last = (pos_r == psfp_pkg::SHORT_LAST);
      psfp_pkg::KIND_LONG:  last = (pos_r == psfp_pkg::LONG_LAST);
      default:              last = (pos_r == psfp_pkg::REPLY_LAST);
    endcase
  end

  always_comb begin
    active_nxt = active_r;
    kind_nxt   = kind_r;
    pos_nxt    = pos_r;
    push       = 1'b0;
    item.kind  = kind_r;
    item.pos   = pos_r;
    item.data  = in_byte;
    item.last  = last;
    if (accept) begin
      if (!active_r) begin
        if (is_id) begin
          push       = 1'b1;
          item.kind  = id_kind;
          item.pos   = '0;
          item.last  = 1'b0;
          active_nxt = 1'b1;
          kind_nxt   = id_kind;
          pos_nxt    = psfp_pkg::POS_W'(1);
        end
      end else begin
        push = 1'b1;
        if (last) begin
          active_nxt = 1'b0;
          pos_nxt    = '0;
        end else begin
          pos_nxt = pos_r + psfp_pkg::POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      kind_r   <= psfp_pkg::KIND_SHORT;
      pos_r    <= '0;
    end else begin
      active_r <= active_nxt;
      kind_r   <= kind_nxt;
      pos_r    <= pos_nxt;
    end
  end

endmodule

[design/psfp_queue.sv]
// Short queue of tagged words between front and back end.
// Depends on psfp_pkg.
module psfp_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  psfp_pkg::item_t push_item,
  input  logic            pop,
  output logic            not_empty,
  output logic            full,
  output psfp_pkg::item_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  psfp_pkg::item_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign head      = mem_r[rd_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[design/psfp_back.sv]
// Back end: header checks, checksums, stored readings and the result register.
// Depends on psfp_pkg.
module psfp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  psfp_pkg::item_t item,
  output logic            pop,
  input  logic            sensor_on,
  input  logic [3:0]      settle_frames,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      out_frame_kind,
  output logic [1:0]      out_frame_status,
  output logic [15:0]     out_pm25_value,
  output logic [15:0]     out_pm10_value,
  output logic            out_readings_valid,
  output logic            out_power_off_request
);

  logic [15:0] sum_r, sum_nxt;
  logic        hg_r, hg_nxt;
  logic [15:0] pend25_r, pend25_nxt, pend10_r, pend10_nxt;
  logic [7:0]  csum_hi_r, csum_hi_nxt;
  logic [3:0]  lfc_r, lfc_nxt;
  logic [15:0] st25_r, st25_nxt, st10_r, st10_nxt;
  logic        vflag_r, vflag_nxt;
  logic        ov_r, ov_nxt;
  logic [1:0]  okind_r, okind_nxt, ostat_r, ostat_nxt;
  logic        opoff_r, opoff_nxt;
  logic        bad;
  logic        hg_cur;
  logic [7:0]  b;
  logic [4:0]  p;
  logic [7:0]  reply_id;

  assign b        = item.data;
  assign p        = item.pos;
  assign pop      = q_valid && (!item.last || !ov_r || !out_stall);
  assign reply_id = (item.kind == psfp_pkg::KIND_NACK) ? psfp_pkg::ID_NACK : psfp_pkg::ID_ACK;

  always_comb begin
    case (item.kind)
      psfp_pkg::KIND_SHORT:
        bad = (p == 5'd1 && b != psfp_pkg::SHORT_HDR1) ||
              (p == 5'd2 && b != psfp_pkg::SHORT_HDR2);
      psfp_pkg::KIND_LONG:
        bad = (p == 5'd1 && b != psfp_pkg::LONG_HDR1) ||
              (p == 5'd2 && b != psfp_pkg::LONG_HDR2) ||
              (p == 5'd3 && b != psfp_pkg::LONG_HDR3);
      default:
        bad = (p == 5'd1 && b != reply_id);
    endcase
    hg_cur = ((p == '0) ? 1'b1 : hg_r) && !bad;
  end

  always_comb begin
    sum_nxt     = sum_r;
    hg_nxt      = hg_r;
    pend25_nxt  = pend25_r;
    pend10_nxt  = pend10_r;
    csum_hi_nxt = csum_hi_r;
    lfc_nxt     = lfc_r;
    st25_nxt    = st25_r;
    st10_nxt    = st10_r;
    vflag_nxt   = vflag_r;
    okind_nxt   = okind_r;
    ostat_nxt   = ostat_r;
    opoff_nxt   = opoff_r;
    ov_nxt      = ov_r && out_stall;
    if (pop) begin
      hg_nxt = hg_cur;
      if (p == '0) begin
        sum_nxt = {8'd0, b};
      end else if ((item.kind == psfp_pkg::KIND_SHORT && p < psfp_pkg::SHORT_LAST) ||
                   (item.kind == psfp_pkg::KIND_LONG && p < psfp_pkg::LONG_CSUM_HI)) begin
        sum_nxt = sum_r + {8'd0, b};
      end
      if (item.kind == psfp_pkg::KIND_SHORT) begin
        case (p)
          5'd3:    pend25_nxt[15:8] = b;
          5'd4:    pend25_nxt[7:0]  = b;
          5'd5:    pend10_nxt[15:8] = b;
          5'd6:    pend10_nxt[7:0]  = b;
          default: ;
        endcase
      end else if (item.kind == psfp_pkg::KIND_LONG) begin
        case (p)
          5'd6:                   pend25_nxt[15:8] = b;
          5'd7:                   pend25_nxt[7:0]  = b;
          5'd8:                   pend10_nxt[15:8] = b;
          5'd9:                   pend10_nxt[7:0]  = b;
          psfp_pkg::LONG_CSUM_HI: csum_hi_nxt      = b;
          default: ;
        endcase
      end
      if (item.last) begin
        ov_nxt    = 1'b1;
        okind_nxt = item.kind;
        ostat_nxt = psfp_pkg::STAT_OK;
        opoff_nxt = 1'b0;
        if (item.kind == psfp_pkg::KIND_NACK || item.kind == psfp_pkg::KIND_ACK) begin
          ostat_nxt = hg_cur ? psfp_pkg::STAT_OK : psfp_pkg::STAT_BODY;
        end else if (!hg_cur) begin
          ostat_nxt = psfp_pkg::STAT_HEADER;
        end else if (item.kind == psfp_pkg::KIND_SHORT) begin
          if (b != (8'd0 - sum_r[7:0])) begin
            ostat_nxt = psfp_pkg::STAT_CHECKSUM;
          end else begin
            st25_nxt  = pend25_r;
            st10_nxt  = pend10_r;
            vflag_nxt = 1'b1;
          end
        end else begin
          if ({csum_hi_r, b} != sum_r) begin
            ostat_nxt = psfp_pkg::STAT_CHECKSUM;
          end else begin
            st25_nxt = pend25_r;
            st10_nxt = pend10_r;
            if (lfc_r > settle_frames) begin
              vflag_nxt = 1'b1;
              opoff_nxt = sensor_on;
              lfc_nxt   = '0;
            end else begin
              lfc_nxt = lfc_r + 4'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_r     <= sum_nxt;
    hg_r      <= hg_nxt;
    pend25_r  <= pend25_nxt;
    pend10_r  <= pend10_nxt;
    csum_hi_r <= csum_hi_nxt;
    okind_r   <= okind_nxt;
    ostat_r   <= ostat_nxt;
    opoff_r   <= opoff_nxt;
    if (!rst_n) begin
      lfc_r   <= '0;
      st25_r  <= '0;
      st10_r  <= '0;
      vflag_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      lfc_r   <= lfc_nxt;
      st25_r  <= st25_nxt;
      st10_r  <= st10_nxt;
      vflag_r <= vflag_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid             = ov_r;
  assign out_frame_kind        = okind_r;
  assign out_frame_status      = ostat_r;
  assign out_pm25_value        = st25_r;
  assign out_pm10_value        = st10_r;
  assign out_readings_valid    = vflag_r;
  assign out_power_off_request = opoff_r;

endmodule

[design/particle_sensor_frame_parser.sv]
// Particle sensor frame parser top level: register port, front end, queue, back end.
// Depends on psfp_pkg, psfp_front, psfp_queue and psfp_back.
//
// Takes one received serial word per cycle while in_stall is low, sustained, with no gaps between frames.
// Idle bytes that are not a frame id are taken and dropped. Every frame word
// passes the front end into a queue of QUEUE_DEPTH entries and is worked by the
// back end at one word per cycle unless a held result stalls a last word; the frame
// result is registered and appears on the out_ port in the cycle after the back end
// takes its last word. in_stall rises only when the queue is full, which happens
// while a finished result is held by out_stall and the back end waits on the next
// last word. sensor_on sits at address 0 and settle_frames at address 4; write them
// only while no frame is in progress.
module particle_sensor_frame_parser #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_frame_kind,
  output logic [1:0]  out_frame_status,
  output logic [15:0] out_pm25_value,
  output logic [15:0] out_pm10_value,
  output logic        out_readings_valid,
  output logic        out_power_off_request
);

  logic            sensor_on_r;
  logic [3:0]      settle_r;
  logic            wr_en;
  logic            accept;
  logic            push;
  logic            pop;
  logic            q_valid;
  logic            q_full;
  psfp_pkg::item_t push_item;
  psfp_pkg::item_t head;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign prdata = (paddr[2] == psfp_pkg::REG_SETTLE_FRAMES) ? {28'd0, settle_r}
                                                             : {31'd0, sensor_on_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_on_r <= 1'b0;
      settle_r    <= 4'd2;
    end else if (wr_en) begin
      if (paddr[2] == psfp_pkg::REG_SENSOR_ON) begin
        sensor_on_r <= pwdata[0];
      end else begin
        settle_r <= pwdata[3:0];
      end
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  psfp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_byte),
    .push    (push),
    .item    (push_item)
  );

  psfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .not_empty (q_valid),
    .full      (q_full),
    .head      (head)
  );

  psfp_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_valid               (q_valid),
    .item                  (head),
    .pop                   (pop),
    .sensor_on             (sensor_on_r),
    .settle_frames         (settle_r),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_frame_kind        (out_frame_kind),
    .out_frame_status      (out_frame_status),
    .out_pm25_value        (out_pm25_value),
    .out_pm10_value        (out_pm10_value),
    .out_readings_valid    (out_readings_valid),
    .out_power_off_request (out_power_off_request)
  );

endmodule

[design/psfp_checker.sv]
// Port-level checks for the particle sensor frame parser, bound to the top level.
// Depends on psfp_pkg and particle_sensor_frame_parser_macros.svh.
`include "particle_sensor_frame_parser_macros.svh"

module psfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_frame_kind,
  input logic [1:0]  out_frame_status,
  input logic [15:0] out_pm25_value,
  input logic [15:0] out_pm10_value,
  input logic        out_readings_valid,
  input logic        out_power_off_request
);

  `PSFP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_frame_kind) && $stable(out_frame_status) && $stable(out_pm25_value) && $stable(out_pm10_value) && $stable(out_readings_valid) && $stable(out_power_off_request), "result word changed while stalled")
  `PSFP_ASSERT_NOW(a_poff_good_long, out_valid && out_power_off_request, out_frame_kind == psfp_pkg::KIND_LONG && out_frame_status == psfp_pkg::STAT_OK && out_readings_valid, "power-off request without a good settled long frame")
  `PSFP_ASSERT_NOW(a_body_reply, out_valid && out_frame_status == psfp_pkg::STAT_BODY, out_frame_kind == psfp_pkg::KIND_NACK || out_frame_kind == psfp_pkg::KIND_ACK, "body mismatch on a measurement frame")
  `PSFP_ASSERT_NOW(a_meas_status, out_valid && (out_frame_status == psfp_pkg::STAT_HEADER || out_frame_status == psfp_pkg::STAT_CHECKSUM), out_frame_kind == psfp_pkg::KIND_SHORT || out_frame_kind == psfp_pkg::KIND_LONG, "header or checksum status on a reply frame")

endmodule

bind particle_sensor_frame_parser psfp_checker u_psfp_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_frame_kind        (out_frame_kind),
  .out_frame_status      (out_frame_status),
  .out_pm25_value        (out_pm25_value),
  .out_pm10_value        (out_pm10_value),
  .out_readings_valid    (out_readings_valid),
  .out_power_off_request (out_power_off_request)
);
